// ----- hdl/mss_pkg.sv -----
// Package for the motor startup sequencer: drive mode and startup phase codes,
// limits, configuration and pipeline item structs. No dependencies.
`timescale 1ns / 1ps

package mss_pkg;

   typedef enum logic [1:0] {
      MODE_STOP       = 2'd0,
      MODE_OPEN       = 2'd1,
      MODE_SENSORLESS = 2'd2
   } mode_type;

   typedef enum logic [2:0] {
      PH_IDLE     = 3'd0,
      PH_ALIGN    = 3'd1,
      PH_OPEN     = 3'd2,
      PH_HANDOVER = 3'd3,
      PH_DONE     = 3'd4
   } phase_type;

   typedef enum logic [2:0] {
      REG_TICK_US        = 3'd0,
      REG_MAX_RPM        = 3'd1,
      REG_ALIGN_US       = 3'd2,
      REG_OPENLOOP_US    = 3'd3,
      REG_LOCK_US        = 3'd4,
      REG_HANDOVER_OMEGA = 3'd5,
      REG_OPENLOOP_STEP  = 3'd6
   } reg_index_type;

   localparam int unsigned CSR_DATA_W = 23;

   localparam logic [19:0] TIMER_MAX    = 20'hFFFFF;
   localparam logic [4:0]  LOCK_MAX     = 5'd31;
   localparam logic [4:0]  LOCK_LIMIT   = 5'd20;
   localparam logic [17:0] ALIGN_MA     = 18'd2000;
   localparam logic [17:0] OPEN_BASE_MA = 18'd5000;
   localparam logic [15:0] RPM_FLOOR    = 16'd500;
   localparam logic [15:0] RPM_DEFAULT  = 16'd6000;
   // throttle*50 < 65535 is throttle <= 1310; throttle*20 > 65535 is throttle >= 3277
   localparam logic [15:0] THR_STOP_MAX  = 16'd1310;
   localparam logic [15:0] THR_START_MIN = 16'd3277;

   localparam logic [1:0] ESC_ARMED2  = 2'd1;
   localparam logic [1:0] ESC_RUNNING = 2'd2;

   typedef struct packed {
      logic [15:0] tick_us;
      logic [15:0] max_rpm;
      logic [19:0] align_us;
      logic [19:0] openloop_us;
      logic [19:0] lock_us;
      logic [22:0] handover_omega;
      logic [15:0] openloop_step;
   } cfg_type;

   // one input item after the front register, with its throttle math done
   typedef struct packed {
      logic        tick;
      logic        esc_ok;
      logic        armed_low;
      logic        thr_start;
      logic        fast;
      logic [31:0] product;
      logic [15:0] obs_angle;
   } item_type;

endpackage

// ----- hdl/mss_front.sv -----
// Front register of the motor startup sequencer: captures a request transfer,
// forms throttle * rpm limit and the threshold flags. Depends on mss_pkg.
`timescale 1ns / 1ps

module mss_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_func,
   input  logic [15:0]                req_throttle,
   input  logic [1:0]                 req_esc_state,
   input  logic signed [23:0]         req_observer_omega,
   input  logic [15:0]                req_observer_angle,
   input  mss_pkg::cfg_type           cfg,
   input  logic                       item_take,
   output logic                       item_valid,
   output mss_pkg::item_type          item
);
   import mss_pkg::*;

   logic        valid_ff, valid_in;
   item_type    item_ff, item_in;
   logic [15:0] rpm_max;
   logic        accept;

   assign req_stall = valid_ff & ~item_take;
   assign accept    = req_valid & ~req_stall;

   always_comb begin
      rpm_max = (cfg.max_rpm < RPM_FLOOR) ? RPM_DEFAULT : cfg.max_rpm;
      item_in.tick      = req_func;
      item_in.esc_ok    = (req_esc_state == ESC_ARMED2) || (req_esc_state == ESC_RUNNING);
      item_in.armed_low = (req_esc_state == ESC_ARMED2) && (req_throttle <= THR_STOP_MAX);
      item_in.thr_start = (req_throttle >= THR_START_MIN);
      // signed speed against the unsigned threshold, both widened to 25 bits
      item_in.fast      = $signed({req_observer_omega[23], req_observer_omega})
                          > $signed({2'b00, cfg.handover_omega});
      item_in.product   = 32'(req_throttle) * 32'(rpm_max);
      item_in.obs_angle = req_observer_angle;
      valid_in = accept | (valid_ff & ~item_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ----- hdl/mss_core.sv -----
// Startup state and result register of the motor startup sequencer: mode and
// phase machine, timer, lock counter, angle integrator. Depends on mss_pkg.
`timescale 1ns / 1ps

module mss_core (
   input  logic              clock,
   input  logic              reset,
   input  mss_pkg::cfg_type  cfg,
   input  logic              item_valid,
   input  mss_pkg::item_type item,
   output logic              item_take,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [1:0]        rsp_drive_mode,
   output logic [2:0]        rsp_start_phase_out,
   output logic [15:0]       rsp_speed_target_rpm,
   output logic [17:0]       rsp_current_ref_ma,
   output logic              rsp_current_ref_owned,
   output logic [15:0]       rsp_elec_angle
);
   import mss_pkg::*;

   mode_type    mode_ff, mode_in;
   phase_type   phase_ff, phase_in;
   logic [19:0] timer_ff, timer_in;
   logic [4:0]  lock_ff, lock_in;
   logic [15:0] angle_ff, angle_in;
   logic [15:0] speed_ff, speed_in;
   logic [17:0] cur_ff, cur_in;
   logic        rsp_valid_ff, rsp_valid_in;

   logic [1:0]  out_mode_ff;
   logic [2:0]  out_phase_ff;
   logic [15:0] out_speed_ff;
   logic [17:0] out_cur_ff;
   logic        out_owned_ff;
   logic [15:0] out_angle_ff;

   logic [15:0] quot;
   logic [16:0] rem0;
   logic [20:0] timer_sum;
   logic [19:0] timer_sat;

   assign item_take = item_valid & (~rsp_valid_ff | ~rsp_stall);

   always_comb begin
      // divide by 65535: x>>16 plus one when the folded remainder reaches 65535
      rem0 = {1'b0, item.product[15:0]} + {1'b0, item.product[31:16]};
      quot = item.product[31:16] + ((rem0 >= 17'd65535) ? 16'd1 : 16'd0);
      timer_sum = {1'b0, timer_ff} + {5'd0, cfg.tick_us};
      timer_sat = timer_sum[20] ? TIMER_MAX : timer_sum[19:0];

      mode_in  = mode_ff;
      phase_in = phase_ff;
      timer_in = timer_ff;
      lock_in  = lock_ff;
      angle_in = angle_ff;
      speed_in = speed_ff;
      cur_in   = cur_ff;

      if (item_take) begin
         if (!item.tick) begin
            if (!item.esc_ok) begin
               mode_in  = MODE_STOP;
               phase_in = PH_IDLE;
               cur_in   = '0;
               speed_in = '0;
            end else begin
               speed_in = quot;
               if (item.armed_low) begin
                  mode_in  = MODE_STOP;
                  phase_in = PH_IDLE;
                  cur_in   = '0;
               end else if (phase_ff == PH_DONE && item.fast) begin
                  mode_in = MODE_SENSORLESS;
               end else if (phase_ff != PH_IDLE) begin
                  mode_in = MODE_OPEN;
               end else if (item.thr_start) begin
                  phase_in = PH_ALIGN;
                  timer_in = '0;
                  lock_in  = '0;
                  mode_in  = MODE_OPEN;
               end
            end
         end else if (mode_ff == MODE_SENSORLESS) begin
            angle_in = item.obs_angle;
         end else if (mode_ff == MODE_OPEN) begin
            timer_in = timer_sat;
            case (phase_ff)
               PH_ALIGN: begin
                  angle_in = '0;
                  cur_in   = ALIGN_MA;
                  if (timer_sat > cfg.align_us) begin
                     phase_in = PH_OPEN;
                     timer_in = '0;
                  end
               end
               PH_OPEN: begin
                  angle_in = angle_ff + cfg.openloop_step;
                  cur_in   = OPEN_BASE_MA + {1'b0, speed_ff, 1'b0};
                  if (item.fast) begin
                     lock_in = (lock_ff < LOCK_MAX) ? lock_ff + 5'd1 : lock_ff;
                  end else begin
                     lock_in = '0;
                  end
                  if (lock_in > LOCK_LIMIT || timer_sat > cfg.openloop_us) begin
                     phase_in = PH_HANDOVER;
                     timer_in = '0;
                  end
               end
               PH_HANDOVER: begin
                  angle_in = item.obs_angle;
                  if (timer_sat > cfg.lock_us) begin
                     phase_in = PH_DONE;
                  end
               end
               default: begin
               end
            endcase
         end
      end

      rsp_valid_in = item_take | (rsp_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_STOP;
         phase_ff     <= PH_IDLE;
         timer_ff     <= '0;
         lock_ff      <= '0;
         angle_ff     <= '0;
         speed_ff     <= '0;
         cur_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         phase_ff     <= phase_in;
         timer_ff     <= timer_in;
         lock_ff      <= lock_in;
         angle_ff     <= angle_in;
         speed_ff     <= speed_in;
         cur_ff       <= cur_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result register: load the state after the update on each transfer
   always_ff @(posedge clock) begin
      if (item_take) begin
         out_mode_ff  <= mode_in;
         out_phase_ff <= phase_in;
         out_speed_ff <= speed_in;
         out_cur_ff   <= (mode_in == MODE_SENSORLESS) ? 18'd0 : cur_in;
         out_owned_ff <= (mode_in != MODE_SENSORLESS);
         out_angle_ff <= angle_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_drive_mode        = out_mode_ff;
   assign rsp_start_phase_out   = out_phase_ff;
   assign rsp_speed_target_rpm  = out_speed_ff;
   assign rsp_current_ref_ma    = out_cur_ff;
   assign rsp_current_ref_owned = out_owned_ff;
   assign rsp_elec_angle        = out_angle_ff;

   a_sensorless_done: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_SENSORLESS |-> phase_ff == PH_DONE)
      else $error("sensorless mode outside done phase");

   a_stop_idle: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_STOP) == (phase_ff == PH_IDLE))
      else $error("stop mode and idle phase disagree");

   a_ramp_timer_clear: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_ALIGN && phase_in == PH_OPEN |=> timer_ff == '0)
      else $error("timer not cleared on entry to open loop ramp");

   a_take_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      item_take |=> rsp_valid_ff)
      else $error("transfer from front register lost");

endmodule

// ----- hdl/motor_startup_sequencer.sv -----
// Motor startup sequencer. A request transfer passes through the front register,
// then the state update into the result register, and the result shows there.
// Throughput: one item per cycle while rsp_stall stays low; the state update is the loop.
// Reset (synchronous, active high): stop mode, idle phase, timer, lock count,
// angle, speed and current cleared; configuration registers return to their defaults.
`timescale 1ns / 1ps

module motor_startup_sequencer (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_func,
   input  logic [15:0]                    req_throttle,
   input  logic [1:0]                     req_esc_state,
   input  logic signed [23:0]             req_observer_omega,
   input  logic [15:0]                    req_observer_angle,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [1:0]                     rsp_drive_mode,
   output logic [2:0]                     rsp_start_phase_out,
   output logic [15:0]                    rsp_speed_target_rpm,
   output logic [17:0]                    rsp_current_ref_ma,
   output logic                           rsp_current_ref_owned,
   output logic [15:0]                    rsp_elec_angle,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [2:0]                     csr_index,
   input  logic [mss_pkg::CSR_DATA_W-1:0] csr_data
);
   import mss_pkg::*;

   cfg_type  cfg_ff;
   logic     item_valid;
   logic     item_take;
   item_type item;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tick_us        <= 16'd50;
         cfg_ff.max_rpm        <= 16'd6000;
         cfg_ff.align_us       <= 20'd80000;
         cfg_ff.openloop_us    <= 20'd400000;
         cfg_ff.lock_us        <= 20'd100000;
         cfg_ff.handover_omega <= 23'd20480;
         cfg_ff.openloop_step  <= 16'd16;
      end else if (csr_valid && csr_ready) begin
         case (reg_index_type'(csr_index))
            REG_TICK_US:        cfg_ff.tick_us        <= csr_data[15:0];
            REG_MAX_RPM:        cfg_ff.max_rpm        <= csr_data[15:0];
            REG_ALIGN_US:       cfg_ff.align_us       <= csr_data[19:0];
            REG_OPENLOOP_US:    cfg_ff.openloop_us    <= csr_data[19:0];
            REG_LOCK_US:        cfg_ff.lock_us        <= csr_data[19:0];
            REG_HANDOVER_OMEGA: cfg_ff.handover_omega <= csr_data[22:0];
            REG_OPENLOOP_STEP:  cfg_ff.openloop_step  <= csr_data[15:0];
            default: begin
            end
         endcase
      end
   end

   mss_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_func           (req_func),
      .req_throttle       (req_throttle),
      .req_esc_state      (req_esc_state),
      .req_observer_omega (req_observer_omega),
      .req_observer_angle (req_observer_angle),
      .cfg                (cfg_ff),
      .item_take          (item_take),
      .item_valid         (item_valid),
      .item               (item)
   );

   mss_core u_core (
      .clock                 (clock),
      .reset                 (reset),
      .cfg                   (cfg_ff),
      .item_valid            (item_valid),
      .item                  (item),
      .item_take             (item_take),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_drive_mode        (rsp_drive_mode),
      .rsp_start_phase_out   (rsp_start_phase_out),
      .rsp_speed_target_rpm  (rsp_speed_target_rpm),
      .rsp_current_ref_ma    (rsp_current_ref_ma),
      .rsp_current_ref_owned (rsp_current_ref_owned),
      .rsp_elec_angle        (rsp_elec_angle)
   );

endmodule
